// ----- hdl/tksyn_pkg.sv -----
package tksyn_pkg;

    localparam int KEEP_COUNT_DEF = 10;
    localparam int NAME_WORDS_DEF = 4;
    localparam int MAX_KEEP       = 64;
    localparam int MAX_NAME_WORDS = 8;
    localparam int MAX_EMIT       = 10;
    localparam int IN_NAME_FIELDS = 4;
    localparam int ID_W           = 12;
    localparam int YEAR_W         = 12;
    localparam int RANK_W         = 4;
    localparam int WORD_BITS      = 64;
    localparam int FILL_W         = $clog2(MAX_KEEP + 1);
    localparam int WORD_W         = $clog2(MAX_NAME_WORDS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_INSERT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              load;
        logic              cmp_en;
        logic [WORD_W-1:0] cmp_word;
        logic              insert;
        logic              emit;
        logic              emit_last;
        logic [RANK_W-1:0] emit_idx;
    } cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              last_flag;
        logic              out_free;
    } sts_t;

    // strcmp over one big-endian word: {stop, ge}. stop is set at the first
    // differing byte or at a shared zero byte; ge is new >= kept there.
    function automatic logic [1:0] word_cmp(input logic [WORD_BITS-1:0] a,
                                            input logic [WORD_BITS-1:0] b);
        logic       stop;
        logic       ge;
        logic [7:0] ca;
        logic [7:0] cb;
        stop = 1'b0;
        ge   = 1'b1;
        for (int k = 0; k < 8; k++) begin
            ca = a[WORD_BITS-1-8*k -: 8];
            cb = b[WORD_BITS-1-8*k -: 8];
            if (!stop) begin
                if (ca != cb) begin
                    stop = 1'b1;
                    ge   = (ca > cb);
                end
                else if (ca == 8'd0) begin
                    stop = 1'b1;
                    ge   = 1'b1;
                end
            end
        end
        return {stop, ge};
    endfunction

endpackage

// ----- hdl/tksyn_ctrl.sv -----
module tksyn_ctrl
    import tksyn_pkg::*;
#(
    parameter int NAME_WORDS = NAME_WORDS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [RANK_W-1:0] idx_reg, idx_next;
    logic [FILL_W-1:0] emit_n;
    logic              emit_last;

    assign emit_n    = (sts.fill > FILL_W'(MAX_EMIT)) ? FILL_W'(MAX_EMIT) : sts.fill;
    assign emit_last = (FILL_W'(idx_reg) + FILL_W'(1)) == emit_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            word_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CMP;
                    word_next  = '0;
                end
            end
            ST_CMP:
            begin
                cmd.cmp_en   = 1'b1;
                cmd.cmp_word = word_reg;
                if (word_reg == WORD_W'(NAME_WORDS - 1))
                    state_next = ST_INSERT;
                else
                    word_next = word_reg + WORD_W'(1);
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                idx_next   = '0;
                state_next = sts.last_flag ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                // hold while the output register is still occupied
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = emit_last;
                    cmd.emit_idx  = idx_reg;
                    if (emit_last)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + RANK_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/tksyn_dp.sv -----
module tksyn_dp
    import tksyn_pkg::*;
#(
    parameter int KEEP_COUNT = KEEP_COUNT_DEF,
    parameter int NAME_WORDS = NAME_WORDS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [ID_W-1:0]      player_id,
    input  logic [YEAR_W-1:0]    birth_year,
    input  logic [WORD_BITS-1:0] name_word_0,
    input  logic [WORD_BITS-1:0] name_word_1,
    input  logic [WORD_BITS-1:0] name_word_2,
    input  logic [WORD_BITS-1:0] name_word_3,
    input  logic                 last_item,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ID_W-1:0]      out_player_id,
    output logic [YEAR_W-1:0]    out_birth_year,
    output logic [RANK_W-1:0]    rank,
    output logic                 last_result
);

    // incoming record
    logic [ID_W-1:0]      new_id_reg;
    logic [YEAR_W-1:0]    new_year_reg;
    logic [WORD_BITS-1:0] new_name_reg [NAME_WORDS];
    logic                 last_reg;
    logic [WORD_BITS-1:0] in_words [IN_NAME_FIELDS];

    // kept cells, sorted by rank
    logic [ID_W-1:0]      id_reg   [KEEP_COUNT];
    logic [YEAR_W-1:0]    year_reg [KEEP_COUNT];
    logic [WORD_BITS-1:0] name_reg [KEEP_COUNT][NAME_WORDS];
    logic                 dec_reg  [KEEP_COUNT];
    logic                 ge_reg   [KEEP_COUNT];
    logic [FILL_W-1:0]    fill_reg;

    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [YEAR_W-1:0]    out_year_reg;
    logic [RANK_W-1:0]    out_rank_reg;
    logic                 out_last_reg;

    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] kept_word [KEEP_COUNT];
    logic [1:0]           wcmp      [KEEP_COUNT];
    logic                 g         [KEEP_COUNT];
    logic                 prev_g    [KEEP_COUNT];
    logic [ID_W-1:0]      sel_id;
    logic [YEAR_W-1:0]    sel_year;

    assign in_words[0] = name_word_0;
    assign in_words[1] = name_word_1;
    assign in_words[2] = name_word_2;
    assign in_words[3] = name_word_3;

    always_comb
    begin
        new_word = '0;
        for (int w = 0; w < NAME_WORDS; w++)
        begin
            if (WORD_W'(w) == cmd.cmp_word)
                new_word = new_name_reg[w];
        end
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            kept_word[i] = '0;
            for (int w = 0; w < NAME_WORDS; w++)
            begin
                if (WORD_W'(w) == cmd.cmp_word)
                    kept_word[i] = name_reg[i][w];
            end
            wcmp[i] = word_cmp(new_word, kept_word[i]);
            // new key >= kept key; an undecided compare means equal names
            g[i] = (FILL_W'(i) < fill_reg) && (dec_reg[i] ? ge_reg[i] : 1'b1);
        end
        prev_g[0] = 1'b1;
        for (int i = 1; i < KEEP_COUNT; i++)
            prev_g[i] = g[i-1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            new_id_reg   <= player_id;
            new_year_reg <= birth_year;
            last_reg     <= last_item;
            for (int w = 0; w < NAME_WORDS; w++)
                new_name_reg[w] <= (w < IN_NAME_FIELDS) ? in_words[w] : '0;
            for (int i = 0; i < KEEP_COUNT; i++)
                dec_reg[i] <= 1'b0;
        end
        if (cmd.cmp_en)
        begin
            for (int i = 0; i < KEEP_COUNT; i++)
            begin
                if (!dec_reg[i])
                begin
                    if (cmd.cmp_word == '0 && new_year_reg != year_reg[i])
                    begin
                        dec_reg[i] <= 1'b1;
                        ge_reg[i]  <= (new_year_reg > year_reg[i]);
                    end
                    else if (wcmp[i][1])
                    begin
                        dec_reg[i] <= 1'b1;
                        ge_reg[i]  <= wcmp[i][0];
                    end
                end
            end
        end
        if (cmd.insert)
        begin
            // write the new record at its slot, shift the cells after it down
            for (int i = 0; i < KEEP_COUNT; i++)
            begin
                if (prev_g[i] && !g[i])
                begin
                    id_reg[i]   <= new_id_reg;
                    year_reg[i] <= new_year_reg;
                    for (int w = 0; w < NAME_WORDS; w++)
                        name_reg[i][w] <= new_name_reg[w];
                end
            end
            for (int i = 1; i < KEEP_COUNT; i++)
            begin
                if (!prev_g[i])
                begin
                    id_reg[i]   <= id_reg[i-1];
                    year_reg[i] <= year_reg[i-1];
                    for (int w = 0; w < NAME_WORDS; w++)
                        name_reg[i][w] <= name_reg[i-1][w];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (cmd.emit && cmd.emit_last)
            fill_reg <= '0;
        else if (cmd.insert && !g[KEEP_COUNT-1] && fill_reg < FILL_W'(KEEP_COUNT))
            fill_reg <= fill_reg + FILL_W'(1);
    end

    always_comb
    begin
        sel_id   = '0;
        sel_year = '0;
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            if (i == int'(cmd.emit_idx))
            begin
                sel_id   = id_reg[i];
                sel_year = year_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_id_reg   <= sel_id;
            out_year_reg <= sel_year;
            out_rank_reg <= cmd.emit_idx;
            out_last_reg <= cmd.emit_last;
        end
    end

    assign sts.fill      = fill_reg;
    assign sts.last_flag = last_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_player_id  = out_id_reg;
    assign out_birth_year = out_year_reg;
    assign rank           = out_rank_reg;
    assign last_result    = out_last_reg;

endmodule

// ----- hdl/top_k_smallest_by_year_name_unit.sv -----
// Channel   Handshake            Payload
// input     in_valid/in_ready    player_id, birth_year, name_word_0..3, last_item
// output    out_valid/out_ready  out_player_id, out_birth_year, rank, last_result
//
// A record is taken in, then runs a word-serial compare over its NAME_WORDS name
// words that every kept cell runs in parallel, and is then inserted with a shift.
// A record flagged last then emits one result per cycle while out_ready is high;
// a stalled output holds the emission.
// rst_n clears the fill count and the controller at once; kept cells hold no reset.
module top_k_smallest_by_year_name_unit
    import tksyn_pkg::*;
#(
    parameter int KEEP_COUNT = KEEP_COUNT_DEF,
    parameter int NAME_WORDS = NAME_WORDS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ID_W-1:0]      player_id,
    input  logic [YEAR_W-1:0]    birth_year,
    input  logic [WORD_BITS-1:0] name_word_0,
    input  logic [WORD_BITS-1:0] name_word_1,
    input  logic [WORD_BITS-1:0] name_word_2,
    input  logic [WORD_BITS-1:0] name_word_3,
    input  logic                 last_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ID_W-1:0]      out_player_id,
    output logic [YEAR_W-1:0]    out_birth_year,
    output logic [RANK_W-1:0]    rank,
    output logic                 last_result
);

    cmd_t cmd;
    sts_t sts;

    tksyn_ctrl #(
        .NAME_WORDS (NAME_WORDS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tksyn_dp #(
        .KEEP_COUNT (KEEP_COUNT),
        .NAME_WORDS (NAME_WORDS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .player_id      (player_id),
        .birth_year     (birth_year),
        .name_word_0    (name_word_0),
        .name_word_1    (name_word_1),
        .name_word_2    (name_word_2),
        .name_word_3    (name_word_3),
        .last_item      (last_item),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_player_id  (out_player_id),
        .out_birth_year (out_birth_year),
        .rank           (rank),
        .last_result    (last_result)
    );

    // one record in flight: no transfer right after a transfer
    a_single_record: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a record is in flight");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sts.fill <= FILL_W'(KEEP_COUNT))
        else $error("fill count beyond kept depth");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rank < RANK_W'(MAX_EMIT))
        else $error("rank beyond emit limit");

    // emission and a new record never overlap
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !in_ready && !cmd.insert)
        else $error("emission overlaps record processing");

endmodule
